// File: rtl/clbv_pkg.sv
// shared types and constants for the correlated lognormal basket value unit
package clbv_pkg;

  localparam int unsigned NUM_TERMS   = 12;
  localparam int unsigned SQRT_STEPS  = 20;
  localparam int unsigned SQRT_RAD_W  = 40;
  localparam int unsigned SQRT_ROOT_W = 20;

  // register stages from accepted request to result strobe
  localparam int unsigned LATENCY = 4 + 2 + 3 * NUM_TERMS + 1 + 2;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;

  // configuration register indexes
  localparam logic [2:0] REG_CORRELATION  = 3'd0;
  localparam logic [2:0] REG_VOL_FIRST    = 3'd1;
  localparam logic [2:0] REG_VOL_SECOND   = 3'd2;
  localparam logic [2:0] REG_RATE         = 3'd3;
  localparam logic [2:0] REG_HORIZON      = 3'd4;
  localparam logic [2:0] REG_WEIGHT_FIRST = 3'd5;
  localparam logic [2:0] REG_WEIGHT_SECOND = 3'd6;

  typedef struct packed {
    logic signed [15:0] normal_first;
    logic signed [15:0] normal_second;
  } in_item_t;

  typedef struct packed {
    logic [31:0] basket_value;
    logic        saturated;
  } out_item_t;

  // config-derived operands handed to the datapath
  typedef struct packed {
    logic signed [15:0] rho;
    logic [15:0]        comp;
    logic [25:0]        vol_first;
    logic [25:0]        vol_second;
    logic signed [50:0] drift_t_first;
    logic signed [50:0] drift_t_second;
    logic [15:0]        weight_first;
    logic [15:0]        weight_second;
  } cfg_derived_t;

endpackage

// File: rtl/clbv_isqrt.sv
// iterative floor square root, one result bit per cycle
module clbv_isqrt
  import clbv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SQRT_RAD_W-1:0]   radicand,
  output logic                    busy,
  output logic                    done,
  output logic [SQRT_ROOT_W-1:0]  root
);

  localparam int unsigned CNT_W = $clog2(SQRT_STEPS);

  logic [SQRT_RAD_W-1:0]  rad_r;
  logic [SQRT_ROOT_W+2:0] rem_r;
  logic [SQRT_ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [SQRT_ROOT_W+2:0] rem_sh;
  logic [SQRT_ROOT_W+2:0] trial;

  assign rem_sh = {rem_r[SQRT_ROOT_W:0], rad_r[SQRT_RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r <= {rad_r[SQRT_RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[SQRT_ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[SQRT_ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/clbv_cfg.sv
// configuration registers and precomputed config-derived operands
module clbv_cfg
  import clbv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output logic         busy,
  output cfg_derived_t derived
);

  logic [15:0] corr_r, vol1_r, vol2_r, rate_r, hor_r, wf_r, ws_r;
  logic        pend_r;
  logic [1:0]  settle_r;

  logic signed [31:0]    rho_sq;
  logic [SQRT_RAD_W-1:0] rad_comp, rad_time;
  logic [SQRT_ROOT_W-1:0] root_comp, root_time;
  logic busy_comp, busy_time, done_comp, done_time;

  logic [31:0]        sq1_r, sq2_r;
  logic [35:0]        vm1_r, vm2_r;
  logic signed [33:0] drift1_r, drift2_r;
  logic signed [50:0] dt1_r, dt2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_r <= 16'd0;
      vol1_r <= 16'd3277;
      vol2_r <= 16'd3277;
      rate_r <= 16'd0;
      hor_r  <= 16'd256;
      wf_r   <= 16'd128;
      ws_r   <= 16'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CORRELATION:   corr_r <= cfg_data;
        REG_VOL_FIRST:     vol1_r <= cfg_data;
        REG_VOL_SECOND:    vol2_r <= cfg_data;
        REG_RATE:          rate_r <= cfg_data;
        REG_HORIZON:       hor_r  <= cfg_data;
        REG_WEIGHT_FIRST:  wf_r   <= cfg_data;
        REG_WEIGHT_SECOND: ws_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // recompute roots after reset and after every write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b1;
      settle_r <= 2'd0;
    end else begin
      if (cfg_valid) pend_r <= 1'b1;
      else if (pend_r) pend_r <= 1'b0;
      if (done_comp || done_time) settle_r <= 2'd3;
      else if (settle_r != 2'd0) settle_r <= settle_r - 2'd1;
    end
  end

  assign rho_sq   = $signed(corr_r) * $signed(corr_r);
  assign rad_comp = {9'b0, ONE_Q30} - {8'b0, rho_sq};
  assign rad_time = {hor_r, 24'b0};

  clbv_isqrt u_sqrt_comp (
    .clk(clk), .rst_n(rst_n), .start(pend_r), .radicand(rad_comp),
    .busy(busy_comp), .done(done_comp), .root(root_comp)
  );

  clbv_isqrt u_sqrt_time (
    .clk(clk), .rst_n(rst_n), .start(pend_r), .radicand(rad_time),
    .busy(busy_time), .done(done_time), .root(root_time)
  );

  // free-running drift and volatility products
  always_ff @(posedge clk) begin
    sq1_r    <= vol1_r * vol1_r;
    sq2_r    <= vol2_r * vol2_r;
    vm1_r    <= vol1_r * root_time;
    vm2_r    <= vol2_r * root_time;
    drift1_r <= $signed({{4{rate_r[15]}}, rate_r, 14'b0}) - $signed({2'b0, sq1_r});
    drift2_r <= $signed({{4{rate_r[15]}}, rate_r, 14'b0}) - $signed({2'b0, sq2_r});
    dt1_r    <= drift1_r * $signed({1'b0, hor_r});
    dt2_r    <= drift2_r * $signed({1'b0, hor_r});
  end

  assign busy = pend_r | busy_comp | busy_time | done_comp | done_time | (settle_r != 2'd0);

  assign derived.rho            = corr_r;
  assign derived.comp           = root_comp[15:0];
  assign derived.vol_first      = vm1_r[35:10];
  assign derived.vol_second     = vm2_r[35:10];
  assign derived.drift_t_first  = dt1_r;
  assign derived.drift_t_second = dt2_r;
  assign derived.weight_first   = wf_r;
  assign derived.weight_second  = ws_r;

endmodule

// File: rtl/clbv_exp.sv
// pipelined exponential factor: range reduction and series for 2^frac
module clbv_exp
  import clbv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [40:0] x,
  output logic               out_valid,
  output logic [40:0]        factor
);

  typedef struct packed {
    logic [29:0]       t;
    logic signed [7:0] n;
    logic              big;
    logic              tiny;
    logic [31:0]       sum;
  } exp_side_t;

  localparam logic signed [40:0] X_HI = 41'sd285212672;
  localparam logic signed [40:0] X_LO = -41'sd536870912;

  logic               e1_vld_r, e1_big_r, e1_tiny_r;
  logic signed [61:0] e1_lm_r;
  logic [59:0]        ft;

  logic [30:0] term_c [NUM_TERMS];
  exp_side_t   side_c [NUM_TERMS+1];
  logic        vld_c  [NUM_TERMS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) e1_vld_r <= 1'b0;
    else        e1_vld_r <= in_valid;
    e1_big_r  <= (x >= X_HI);
    e1_tiny_r <= (x < X_LO);
    e1_lm_r   <= $signed(x[29:0]) * $signed({1'b0, LOG2E_Q30});
  end

  // split y into integer n and fraction, scale fraction by ln2
  assign ft = e1_lm_r[53:24] * LN2_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_c[0] <= 1'b0;
    else        vld_c[0] <= e1_vld_r;
    side_c[0] <= '{t: ft[59:30], n: e1_lm_r[61:54], big: e1_big_r,
                   tiny: e1_tiny_r, sum: {1'b0, ONE_Q30}};
    term_c[0] <= ONE_Q30;
  end

  for (genvar k = 1; k <= NUM_TERMS; k++) begin : g_term
    localparam int unsigned K     = k;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

    logic [60:0] a_prod;
    logic [30:0] a_v_r, b_v_r;
    exp_side_t   a_s_r, b_s_r;
    logic        a_vld_r, b_vld_r;
    logic [63:0] b_qm_r;
    logic [30:0] q0, q;
    logic [34:0] qk, rem;

    assign a_prod = term_c[k-1] * side_c[k-1].t;
    assign q0     = b_qm_r[62:32];
    assign qk     = q0 * 35'(K);
    assign rem    = {4'b0, b_v_r} - qk;
    assign q      = (rem >= 35'(K)) ? q0 + 31'd1 : q0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r  <= 1'b0;
        b_vld_r  <= 1'b0;
        vld_c[k] <= 1'b0;
      end else begin
        a_vld_r  <= vld_c[k-1];
        b_vld_r  <= a_vld_r;
        vld_c[k] <= b_vld_r;
      end
      a_v_r  <= a_prod[60:30];
      a_s_r  <= side_c[k-1];
      b_qm_r <= a_v_r * RECIP;
      b_v_r  <= a_v_r;
      b_s_r  <= a_s_r;
      side_c[k] <= '{t: b_s_r.t, n: b_s_r.n, big: b_s_r.big, tiny: b_s_r.tiny,
                     sum: b_s_r.sum + {1'b0, q}};
    end

    if (k < NUM_TERMS) begin : g_next
      always_ff @(posedge clk) term_c[k] <= q;
    end
  end

  // scale by 2^(n-14) into q16.16, then clip
  exp_side_t          fs;
  logic signed [7:0]  nd, nneg;
  logic [40:0]        pw, scaled;
  logic [40:0]        factor_r;
  logic               vld_r;

  assign fs   = side_c[NUM_TERMS];
  assign nd   = fs.n - 8'sd14;
  assign nneg = -nd;
  assign pw   = {9'b0, fs.sum};

  always_comb begin
    if (nd >= 8'sd0) scaled = pw << nd[3:0];
    else             scaled = pw >> nneg[5:0];
    if (fs.big)       scaled = 41'd1 << 40;
    else if (fs.tiny) scaled = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_c[NUM_TERMS];
    factor_r <= scaled;
  end

  assign out_valid = vld_r;
  assign factor    = factor_r;

endmodule

// File: rtl/clbv_comb.sv
// weighted sum of the two factors with saturation
module clbv_comb
  import clbv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [40:0] factor_first,
  input  logic [40:0] factor_second,
  input  logic [15:0] weight_first,
  input  logic [15:0] weight_second,
  output logic        out_valid,
  output out_item_t   out_item
);

  logic [56:0] t1_r, t2_r;
  logic        a_vld_r, vld_r;
  logic [57:0] s;
  logic        sat;
  out_item_t   item_r;

  assign s   = {1'b0, t1_r} + {1'b0, t2_r};
  assign sat = |s[57:40];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      a_vld_r <= in_valid;
      vld_r   <= a_vld_r;
    end
    t1_r <= factor_first * weight_first;
    t2_r <= factor_second * weight_second;
    item_r.basket_value <= sat ? 32'hFFFF_FFFF : s[39:8];
    item_r.saturated    <= sat;
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

// File: rtl/correlated_lognormal_basket_value_unit.sv
// top level: correlated two-asset lognormal basket value pipeline
//
// Takes one pair of independent normal samples (q4.12) per cycle whenever busy is low
// and returns w1*exp(x1) + w2*exp(x2) as unsigned q16.16, one strobe on out_valid
// per request, saturating to all ones with the saturated flag.
// The pipeline never stalls: results are shown for one cycle only and must be taken.
// Sustained rate is one request per cycle while busy stays low; latency is set
// by the 2^frac series, a twelve-term chain of multiply, reciprocal multiply and
// correction stages. After reset and after every configuration write, busy stays
// high while two bit-serial square root units (20 steps) form sqrt(1-rho^2)
// and sqrt(T) and the drift and volatility products settle. Write configuration
// only while no request is in flight.
module correlated_lognormal_basket_value_unit
  import clbv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  // result channel
  output logic        out_valid,
  output out_item_t   out_item,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_derived_t cfg_d;
  logic         accept;

  // stage registers of the correlation and exponent front end
  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0] pa_r;
  logic signed [32:0] pb_r;
  logic signed [15:0] z1_r;
  logic signed [33:0] w1_r, w2_r;
  logic signed [59:0] m1_r, m2_r;
  logic signed [63:0] x47_first, x47_second;
  logic signed [40:0] x1_r, x2_r;

  logic        f_vld;
  logic [40:0] f1, f2;

  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  clbv_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid & cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .busy(busy), .derived(cfg_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    // correlate: w2 = rho*z1 + comp*z2 in q27, w1 = z1 in q27
    pa_r <= cfg_d.rho * in_item.normal_first;
    pb_r <= $signed({1'b0, cfg_d.comp}) * in_item.normal_second;
    z1_r <= in_item.normal_first;
    w1_r <= $signed({{3{z1_r[15]}}, z1_r, 15'b0});
    w2_r <= pa_r + pb_r;
    // diffusion term sigma*sqrt(T)*w
    m1_r <= $signed({1'b0, cfg_d.vol_first}) * w1_r;
    m2_r <= $signed({1'b0, cfg_d.vol_second}) * w2_r;
    // exponent in q47, floored to q24
    x1_r <= x47_first[63:23];
    x2_r <= x47_second[63:23];
  end

  assign x47_first  = $signed({{3{cfg_d.drift_t_first[50]}}, cfg_d.drift_t_first, 10'b0})
                    + $signed({{4{m1_r[59]}}, m1_r});
  assign x47_second = $signed({{3{cfg_d.drift_t_second[50]}}, cfg_d.drift_t_second, 10'b0})
                    + $signed({{4{m2_r[59]}}, m2_r});

  clbv_exp u_exp_first (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .x(x1_r),
    .out_valid(f_vld), .factor(f1)
  );

  clbv_exp u_exp_second (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .x(x2_r),
    .out_valid(), .factor(f2)
  );

  clbv_comb u_comb (
    .clk(clk), .rst_n(rst_n), .in_valid(f_vld),
    .factor_first(f1), .factor_second(f2),
    .weight_first(cfg_d.weight_first), .weight_second(cfg_d.weight_second),
    .out_valid(out_valid), .out_item(out_item)
  );

  // every accepted request comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(LATENCY) out_valid)
    else $error("result strobe missing at pipeline depth");

  // a write triggers the root recompute, so requests are held off
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("busy not raised after configuration write");

  // clipped results are full scale
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.saturated) |-> (out_item.basket_value == 32'hFFFF_FFFF))
    else $error("saturated result not at full scale");

endmodule

// File: dv/clbv_checker.sv
// request/result checker with a bit-exact basket value predictor
`timescale 1ns / 100ps
module clbv_checker
  import clbv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam longint LOG2E = 64'd1549082005;
  localparam longint LN2   = 64'd744261118;
  localparam longint ONE   = 64'd1073741824;
  localparam longint CAP   = 64'd1 << 40;

  logic signed [15:0] rho_q, rate_q;
  logic [15:0] vol1_q, vol2_q, horizon_q, wt1_q, wt2_q;
  out_item_t basket_expected[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(f/2^30) in q30 by a twelve-term series
  function automatic longint unsigned pow2_series(longint unsigned f);
    longint unsigned t, sum, term;
    t = (f * LN2) >> 30;
    sum = ONE;
    term = ONE;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * t) >> 30) / k;
      sum = sum + term;
    end
    return sum;
  endfunction

  // q24 exponent to q16.16 factor, clipped at the top and zero below the low bound
  function automatic longint unsigned exp_q16(longint x);
    longint y, n;
    longint unsigned p;
    if (x >= 17 * 64'sd16777216) return CAP;
    if (x < -32 * 64'sd16777216) return 0;
    y = (x * LOG2E) >>> 24;
    n = y >>> 30;
    p = pow2_series(longint'(y - n * ONE));
    if (n >= 14) return p << (n - 14);
    if (14 - n >= 63) return 0;
    return p >> (14 - n);
  endfunction

  function automatic longint unsigned asset_factor(longint sigma, longint sqrt_t,
                                                   longint w_q27, longint rate,
                                                   longint hz);
    longint drift_t, vol_q20, x47;
    drift_t = (rate * 16384 - sigma * sigma) * hz;
    vol_q20 = (sigma * sqrt_t) >>> 10;
    x47 = drift_t * 1024 + vol_q20 * w_q27;
    return exp_q16(x47 >>> 23);
  endfunction

  function automatic out_item_t basket_predict(in_item_t it);
    longint rho, comp, sqrt_t, z1, z2, w2;
    longint unsigned f1, f2, sum;
    out_item_t res;
    rho = longint'(rho_q);
    comp = longint'(int_sqrt(longint'(ONE - rho * rho)));
    sqrt_t = longint'(int_sqrt(longint'(horizon_q) << 24));
    z1 = longint'(it.normal_first);
    z2 = longint'(it.normal_second);
    w2 = rho * z1 + comp * z2;
    f1 = asset_factor(longint'(vol1_q), sqrt_t, z1 * 32768, longint'(rate_q),
                      longint'(horizon_q));
    f2 = asset_factor(longint'(vol2_q), sqrt_t, w2, longint'(rate_q),
                      longint'(horizon_q));
    sum = (f1 * wt1_q + f2 * wt2_q) >> 8;
    if (sum > 64'hFFFF_FFFF) begin
      res.basket_value = 32'hFFFF_FFFF;
      res.saturated = 1'b1;
    end else begin
      res.basket_value = sum[31:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      rho_q <= 16'sd0;
      vol1_q <= 16'd3277;
      vol2_q <= 16'd3277;
      rate_q <= 16'sd0;
      horizon_q <= 16'd256;
      wt1_q <= 16'd128;
      wt2_q <= 16'd128;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CORRELATION:   rho_q <= cfg_data;
          REG_VOL_FIRST:     vol1_q <= cfg_data;
          REG_VOL_SECOND:    vol2_q <= cfg_data;
          REG_RATE:          rate_q <= cfg_data;
          REG_HORIZON:       horizon_q <= cfg_data;
          REG_WEIGHT_FIRST:  wt1_q <= cfg_data;
          REG_WEIGHT_SECOND: wt2_q <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) basket_expected = {basket_expected, basket_predict(in_item)};
      if (out_valid) begin
        if (basket_expected.size() == 0) begin
          $error("result with no request pending: value %h", out_item.basket_value);
          errors++;
        end else begin
          exp_item = basket_expected.pop_front();
          if (exp_item.basket_value !== out_item.basket_value) begin
            $error("basket_value expected %h actual %h",
                   exp_item.basket_value, out_item.basket_value);
            errors++;
          end
          if (exp_item.saturated !== out_item.saturated) begin
            $error("saturated expected %b actual %b",
                   exp_item.saturated, out_item.saturated);
            errors++;
          end
        end
      end
    end
    pending = basket_expected.size();
  end

endmodule

// File: dv/tb.sv
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
module tb;
  import clbv_pkg::*;

  // index past the last register, writes there must be dropped
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          quiet_cycles;

  correlated_lognormal_basket_value_unit dut (.*);

  clbv_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL correlated_lognormal_basket_value_unit");
      $finish;
    end
  end

  // mostly back to back, sometimes short pauses, rarely long ones
  task automatic idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return;
    start <= 1'b0;
    if (pick < 95) repeat ($urandom_range(1, 4)) @(posedge clk);
    else repeat ($urandom_range(10, 60)) @(posedge clk);
  endtask

  // one request; start stays high when the next one follows right away
  task automatic send_request(logic signed [15:0] z1, logic signed [15:0] z2);
    idle_gap();
    start <= 1'b1;
    in_item <= '{normal_first: z1, normal_second: z2};
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // register write, only once every result has come back
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_market(logic [15:0] rho, logic [15:0] v1, logic [15:0] v2,
                            logic [15:0] rate, logic [15:0] hz, logic [15:0] w1,
                            logic [15:0] w2);
    write_reg(REG_CORRELATION, rho);
    write_reg(REG_VOL_FIRST, v1);
    write_reg(REG_VOL_SECOND, v2);
    write_reg(REG_RATE, rate);
    write_reg(REG_HORIZON, hz);
    write_reg(REG_WEIGHT_FIRST, w1);
    write_reg(REG_WEIGHT_SECOND, w2);
  endtask

  // normals mostly within a few sigma, some over the whole field
  function automatic logic [15:0] rand_normal();
    if ($urandom_range(0, 9) < 8) return 16'($signed($urandom_range(0, 32768)) - 16384);
    return 16'($urandom);
  endfunction

  task automatic random_requests(int n);
    for (int i = 0; i < n; i++) send_request(rand_normal(), rand_normal());
  endtask

  // plausible market: moderate vol, rate, horizon and weights
  task automatic random_market();
    set_market(16'($urandom), 16'($urandom_range(0, 8192)),
               16'($urandom_range(0, 8192)), 16'($signed($urandom_range(0, 6554)) - 3277),
               16'($urandom_range(0, 2560)), 16'($urandom_range(0, 1024)),
               16'($urandom_range(0, 1024)));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes and mixed signs
    send_request(16'sd0, 16'sd0);
    send_request(16'sd32767, 16'sd32767);
    send_request(-16'sd32768, -16'sd32768);
    send_request(16'sd32767, -16'sd32768);
    send_request(-16'sd32768, 16'sd32767);
    send_request(16'sd4096, -16'sd4096);
    random_requests(60);

    // perfect negative correlation, second sample drops out
    set_market(16'h8000, 16'd3277, 16'd6554, 16'd1638, 16'd256, 16'd256, 16'd256);
    send_request(16'sd4096, 16'sd32767);
    send_request(-16'sd8192, -16'sd32768);
    random_requests(40);

    // huge vol and horizon: large exponent clips and saturates
    set_market(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(16'sd32767, 16'sd32767);
    send_request(-16'sd32768, -16'sd32768);
    send_request(16'sd0, 16'sd0);
    random_requests(20);

    // clipped factor under zero weight contributes nothing
    set_market(16'h7FFF, 16'hFFFF, 16'd0, 16'h7FFF, 16'd2560, 16'd0, 16'd256);
    send_request(16'sd32767, 16'sd0);
    send_request(-16'sd32768, 16'sd4096);
    random_requests(20);

    // zero vol and horizon, then a dropped write past the last register
    set_market(16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd256, 16'd256);
    write_reg(REG_NONE, 16'hFFFF);
    send_request(16'sd32767, -16'sd32768);
    random_requests(20);

    // strongly negative drift: small exponent gives zero factors
    set_market(16'h4000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h2000, 16'd256, 16'd256);
    send_request(-16'sd32768, -16'sd32768);
    send_request(16'sd0, 16'sd0);
    random_requests(20);

    for (int p = 0; p < 8; p++) begin
      random_market();
      random_requests(40);
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("PASS correlated_lognormal_basket_value_unit");
    else
      $display("FAIL correlated_lognormal_basket_value_unit");
    $finish;
  end

endmodule
